/* sv/baro_pc_pkg.sv */
`timescale 1ns / 1ps
package baro_pc_pkg;

  localparam int RAW_W  = 24;
  localparam int COEF_W = 16;
  localparam int DT_W   = 25;
  localparam int PROD_W = 42;
  localparam int SQ_W   = 50;
  localparam int TP_W   = 19;
  localparam int TM_W   = 20;
  localparam int T2_W   = 19;
  localparam int ACC_W  = 48;
  localparam int RES_W  = 32;
  localparam int SPLIT  = 24;

  localparam logic signed [RES_W-1:0] TEMP_REF    = 32'sd2000;
  localparam logic signed [TM_W-1:0]  TM_OFS      = 20'sd3500;
  localparam logic signed [TP_W-1:0]  TP_VLOW_LIM = -19'sd3500;

  typedef enum logic [2:0] {
    REG_C1 = 3'd0,
    REG_C2 = 3'd1,
    REG_C3 = 3'd2,
    REG_C4 = 3'd3,
    REG_C5 = 3'd4,
    REG_C6 = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [COEF_W-1:0] c1;
    logic [COEF_W-1:0] c2;
    logic [COEF_W-1:0] c3;
    logic [COEF_W-1:0] c4;
    logic [COEF_W-1:0] c5;
    logic [COEF_W-1:0] c6;
  } coef_t;

  // first-order results handed to the correction stages
  typedef struct packed {
    logic [RAW_W-1:0]        d1;
    logic signed [TP_W-1:0]  tp;
    logic signed [TM_W-1:0]  tm;
    logic signed [RES_W-1:0] temp;
    logic [T2_W-1:0]         t2;
    logic signed [ACC_W-1:0] off;
    logic signed [ACC_W-1:0] sens;
    logic                    low;
    logic                    vlow;
  } front_t;

  // corrected terms handed to the pressure stages
  typedef struct packed {
    logic [RAW_W-1:0]        d1;
    logic signed [RES_W-1:0] temp;
    logic signed [ACC_W-1:0] off;
    logic signed [ACC_W-1:0] sens;
  } corr_t;

endpackage

/* sv/baro_pressure_temp_compensation.sv */
`timescale 1ns / 1ps
// Channel   Direction  Word layout (low bit first)
// in_       slave      tdata[23:0] raw_pressure, tdata[47:24] raw_temperature
// out_      master     tdata[31:0] temp_centideg, tdata[63:32] pressure_centimbar
// cfg_      APB        regs C1..C6 at byte addresses 0x00..0x14, 16 bits each
//
// Nine register stages, and one word per cycle goes through when
// out_tready stays high.
// Each stage holds its own valid bit; a stage takes new data when it is empty
// or the next one moves, so bubbles close up while the output waits.
// rst_n clears all valid bits and the coefficients to zero.
module baro_pressure_temp_compensation
  import baro_pc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,    // raw_pressure, raw_temperature
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,   // temp_centideg, pressure_centimbar
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  coef_t                   coef;
  front_t                  front_data;
  corr_t                   corr_data;
  logic                    front_valid, front_ready;
  logic                    corr_valid, corr_ready;
  logic signed [RES_W-1:0] temp;
  logic signed [RES_W-1:0] pressure;

  baro_pc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .coef    (coef)
  );

  baro_pc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .coef      (coef),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .d1        (in_tdata[RAW_W-1:0]),
    .d2        (in_tdata[2*RAW_W-1:RAW_W]),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .out_data  (front_data)
  );

  baro_pc_corr u_corr (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_data   (front_data),
    .out_valid (corr_valid),
    .out_ready (corr_ready),
    .out_data  (corr_data)
  );

  baro_pc_press u_press (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (corr_valid),
    .in_ready  (corr_ready),
    .in_data   (corr_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .temp      (temp),
    .pressure  (pressure)
  );

  assign out_tdata = {pressure, temp};

endmodule

/* sv/baro_pc_cfg.sv */
`timescale 1ns / 1ps
module baro_pc_cfg
  import baro_pc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output coef_t       coef
);

  coef_t    coef_r;
  coef_t    coef_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[4:2]);
  assign coef   = coef_r;

  always_comb begin
    coef_nxt = coef_r;
    if (wr_en) begin
      unique case (idx)
        REG_C1: coef_nxt.c1 = pwdata[COEF_W-1:0];
        REG_C2: coef_nxt.c2 = pwdata[COEF_W-1:0];
        REG_C3: coef_nxt.c3 = pwdata[COEF_W-1:0];
        REG_C4: coef_nxt.c4 = pwdata[COEF_W-1:0];
        REG_C5: coef_nxt.c5 = pwdata[COEF_W-1:0];
        REG_C6: coef_nxt.c6 = pwdata[COEF_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_C1:  prdata = {16'b0, coef_r.c1};
      REG_C2:  prdata = {16'b0, coef_r.c2};
      REG_C3:  prdata = {16'b0, coef_r.c3};
      REG_C4:  prdata = {16'b0, coef_r.c4};
      REG_C5:  prdata = {16'b0, coef_r.c5};
      REG_C6:  prdata = {16'b0, coef_r.c6};
      default: prdata = 32'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else begin
      coef_r <= coef_nxt;
    end
  end

endmodule

/* sv/baro_pc_front.sv */
`timescale 1ns / 1ps
module baro_pc_front
  import baro_pc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  coef_t            coef,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [RAW_W-1:0] d1,
  input  logic [RAW_W-1:0] d2,
  output logic             out_valid,
  input  logic             out_ready,
  output front_t           out_data
);

  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3;

  logic [RAW_W-1:0]         d1_s1_r, d1_s2_r;
  logic signed [DT_W-1:0]   dt_r;
  logic signed [DT_W-1:0]   dt_nxt;
  logic signed [PROD_W-1:0] p6_r, p4_r, p3_r;
  logic signed [SQ_W-1:0]   pdd_r;
  front_t                   s3_r;
  front_t                   s3_nxt;
  logic signed [TP_W-1:0]   tp;

  assign en3      = !v3_r || out_ready;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  assign out_valid = v3_r;
  assign out_data  = s3_r;

  assign dt_nxt = $signed({1'b0, d2}) - $signed({1'b0, coef.c5, 8'b0});

  assign tp = TP_W'(p6_r >>> 23);

  always_comb begin
    s3_nxt      = '0;
    s3_nxt.d1   = d1_s2_r;
    s3_nxt.tp   = tp;
    s3_nxt.tm   = TM_W'(tp) + TM_OFS;
    s3_nxt.temp = RES_W'(tp) + TEMP_REF;
    s3_nxt.t2   = pdd_r[SQ_W-1:31];
    s3_nxt.off  = $signed({15'b0, coef.c2, 17'b0}) + ACC_W'(p4_r >>> 6);
    s3_nxt.sens = $signed({16'b0, coef.c1, 16'b0}) + ACC_W'(p3_r >>> 7);
    s3_nxt.low  = tp < 0;
    s3_nxt.vlow = tp < TP_VLOW_LIM;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      d1_s1_r <= d1;
      dt_r    <= dt_nxt;
    end
    if (en2) begin
      d1_s2_r <= d1_s1_r;
      p6_r    <= dt_r * $signed({1'b0, coef.c6});
      p4_r    <= dt_r * $signed({1'b0, coef.c4});
      p3_r    <= dt_r * $signed({1'b0, coef.c3});
      pdd_r   <= dt_r * dt_r;
    end
    if (en3) begin
      s3_r <= s3_nxt;
    end
  end

endmodule

/* sv/baro_pc_corr.sv */
`timescale 1ns / 1ps
module baro_pc_corr
  import baro_pc_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  front_t in_data,
  output logic   out_valid,
  input  logic   out_ready,
  output corr_t  out_data
);

  logic v4_r, v5_r, v6_r;
  logic en4, en5, en6;

  front_t                   s4_r, s5_r;
  logic signed [2*TP_W-1:0] tp2_r;
  logic signed [2*TM_W-1:0] tm2_r;
  logic signed [ACC_W-1:0]  off2_r, sens2_r;
  logic signed [ACC_W-1:0]  off2_nxt, sens2_nxt;
  logic signed [ACC_W-1:0]  tp2x, tm2x;
  corr_t                    s6_r;
  corr_t                    s6_nxt;

  assign en6      = !v6_r || out_ready;
  assign en5      = !v5_r || en6;
  assign en4      = !v4_r || en5;
  assign in_ready = en4;

  assign out_valid = v6_r;
  assign out_data  = s6_r;

  assign tp2x = ACC_W'(tp2_r);
  assign tm2x = ACC_W'(tm2_r);

  // 61*tp^2/16 and 2*tp^2, plus the deep-cold terms 15*tm^2 and 8*tm^2
  always_comb begin
    off2_nxt  = ((tp2x <<< 6) - (tp2x <<< 2) + tp2x) >>> 4;
    sens2_nxt = tp2x <<< 1;
    if (s4_r.vlow) begin
      off2_nxt  = off2_nxt + ((tm2x <<< 4) - tm2x);
      sens2_nxt = sens2_nxt + (tm2x <<< 3);
    end
  end

  always_comb begin
    s6_nxt      = '0;
    s6_nxt.d1   = s5_r.d1;
    s6_nxt.temp = s5_r.temp;
    s6_nxt.off  = s5_r.off;
    s6_nxt.sens = s5_r.sens;
    if (s5_r.low) begin
      s6_nxt.temp = s5_r.temp - $signed({13'b0, s5_r.t2});
      s6_nxt.off  = s5_r.off - off2_r;
      s6_nxt.sens = s5_r.sens - sens2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (en4) v4_r <= in_valid;
      if (en5) v5_r <= v4_r;
      if (en6) v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_r  <= in_data;
      tp2_r <= in_data.tp * in_data.tp;
      tm2_r <= in_data.tm * in_data.tm;
    end
    if (en5) begin
      s5_r    <= s4_r;
      off2_r  <= off2_nxt;
      sens2_r <= sens2_nxt;
    end
    if (en6) begin
      s6_r <= s6_nxt;
    end
  end

endmodule

/* sv/baro_pc_press.sv */
`timescale 1ns / 1ps
module baro_pc_press
  import baro_pc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  corr_t                   in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [RES_W-1:0] temp,
  output logic signed [RES_W-1:0] pressure
);

  logic v7_r, v8_r, v9_r;
  logic en7, en8, en9;

  logic [2*SPLIT-1:0]        pl_r;
  logic signed [2*SPLIT:0]   ph_r;
  logic signed [RES_W-1:0]   temp7_r, temp8_r, temp9_r;
  logic signed [ACC_W-1:0]   off7_r, off8_r;
  logic signed [63:0]        prod_r;
  logic signed [63:0]        prod_nxt;
  logic signed [63:0]        pw;
  logic signed [RES_W-1:0]   press_r;

  assign en9      = !v9_r || out_ready;
  assign en8      = !v8_r || en9;
  assign en7      = !v7_r || en8;
  assign in_ready = en7;

  assign out_valid = v9_r;
  assign temp      = temp9_r;
  assign pressure  = press_r;

  // recombine the two partial products of d1 * sens
  assign prod_nxt = $signed({16'b0, pl_r}) + (64'(ph_r) <<< SPLIT);
  assign pw       = ((prod_r >>> 21) - 64'(off8_r)) >>> 15;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
      v8_r <= 1'b0;
      v9_r <= 1'b0;
    end else begin
      if (en7) v7_r <= in_valid;
      if (en8) v8_r <= v7_r;
      if (en9) v9_r <= v8_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en7) begin
      pl_r    <= in_data.d1 * in_data.sens[SPLIT-1:0];
      ph_r    <= $signed({1'b0, in_data.d1}) * $signed(in_data.sens[ACC_W-1:SPLIT]);
      temp7_r <= in_data.temp;
      off7_r  <= in_data.off;
    end
    if (en8) begin
      prod_r  <= prod_nxt;
      temp8_r <= temp7_r;
      off8_r  <= off7_r;
    end
    if (en9) begin
      press_r <= pw[RES_W-1:0];
      temp9_r <= temp8_r;
    end
  end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import baro_pc_pkg::*;

  localparam longint TEMP_BREAK  = 2000;
  localparam longint COLD_BREAK  = -1500;
  localparam int     SPARE_IDX   = int'(REG_C6) + 1;
  localparam int     CYCLE_LIMIT = 300000;
  localparam int     LONG_HOLD   = 300;
  localparam logic [RAW_W-1:0] RAW_MAX = '1;

  // datasheet-style calibration set
  localparam coef_t TYPICAL_CAL = '{c1: 16'd40127, c2: 16'd36924, c3: 16'd23317,
                                    c4: 16'd23282, c5: 16'd33464, c6: 16'd28312};

  class reading_tracker;
    coef_t       coefs;
    logic [63:0] due_readings[$];
    int          mismatches;

    function new();
      coefs      = '0;
      mismatches = 0;
    endfunction

    function void set_coef(input int idx, input logic [COEF_W-1:0] val);
      case (idx)
        REG_C1:  coefs.c1 = val;
        REG_C2:  coefs.c2 = val;
        REG_C3:  coefs.c3 = val;
        REG_C4:  coefs.c4 = val;
        REG_C5:  coefs.c5 = val;
        REG_C6:  coefs.c6 = val;
        default: ;  // no register behind this address
      endcase
    endfunction

    // returns {pressure, temperature}, both cut to 32 bits
    function logic [63:0] compensate(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
      longint k1, k2, k3, k4, k5, k6, p_raw, t_raw;
      longint delta_t, t_dev, temp, offset, sens, t_sq_fix, dev_sq, off_fix, sens_fix;
      longint cold, cold_sq, pres;
      k1 = longint'(coefs.c1);
      k2 = longint'(coefs.c2);
      k3 = longint'(coefs.c3);
      k4 = longint'(coefs.c4);
      k5 = longint'(coefs.c5);
      k6 = longint'(coefs.c6);
      p_raw = longint'(d1);
      t_raw = longint'(d2);
      delta_t = t_raw - k5 * 256;
      t_dev   = (delta_t * k6) >>> 23;
      temp    = TEMP_BREAK + t_dev;
      offset  = k2 * 131072 + ((k4 * delta_t) >>> 6);
      sens    = k1 * 65536 + ((k3 * delta_t) >>> 7);
      if (temp < TEMP_BREAK) begin
        t_sq_fix = (delta_t * delta_t) >>> 31;
        dev_sq   = t_dev * t_dev;
        off_fix  = (61 * dev_sq) >>> 4;
        sens_fix = 2 * dev_sq;
        // extra term in the very cold range
        if (temp < COLD_BREAK) begin
          cold     = temp - COLD_BREAK;
          cold_sq  = cold * cold;
          off_fix  = off_fix + 15 * cold_sq;
          sens_fix = sens_fix + 8 * cold_sq;
        end
        temp   = temp - t_sq_fix;
        offset = offset - off_fix;
        sens   = sens - sens_fix;
      end
      pres = (((p_raw * sens) >>> 21) - offset) >>> 15;
      return {pres[31:0], temp[31:0]};
    endfunction

    function void note_sample(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
      due_readings.push_back(compensate(d1, d2));
    endfunction

    function void check_reading(input logic [63:0] word);
      logic [63:0] want;
      if (due_readings.size() == 0) begin
        $display("%0t: unexpected word %h, expected none", $time, word);
        mismatches++;
        return;
      end
      want = due_readings.pop_front();
      if (word[31:0] !== want[31:0]) begin
        $display("%0t: temp_centideg expected %0d actual %0d", $time,
                 $signed(want[31:0]), $signed(word[31:0]));
        mismatches++;
      end
      if (word[63:32] !== want[63:32]) begin
        $display("%0t: pressure_centimbar expected %0d actual %0d", $time,
                 $signed(want[63:32]), $signed(word[63:32]));
        mismatches++;
      end
    endfunction
  endclass

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata    = '0;    // raw_pressure, raw_temperature
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [63:0] out_tdata;           // temp_centideg, pressure_centimbar
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [4:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  logic        rx_hold_req  = 1'b0;
  logic        rx_hold_long = 1'b0;
  bit          rx_calm = 1'b0;
  bit          tx_calm = 1'b0;
  bit          in_live = 1'b0;
  int          rx_wait = 0;
  int          cycle_cnt = 0;

  reading_tracker sb;

  baro_pressure_temp_compensation uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side: random stall per word, sometimes none for a while
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        sb.check_reading(out_tdata);
        if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
        rx_wait = rx_calm ? 0 : $urandom_range(0, 18);
      end else if (rx_wait > 0) begin
        rx_wait = rx_wait - 1;
      end
      out_tready <= (rx_wait == 0) && !rx_hold_long;
    end
  end

  // long back-pressure so the pipeline fills and stalls the input
  initial begin
    wait (rx_hold_req);
    @(posedge clk);
    rx_hold_long <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    rx_hold_long <= 1'b0;
  end

  task automatic send_pair(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
    int gap;
    if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      if (in_live) in_tvalid <= 1'b0;
      in_live = 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {d2, d1};
    in_live = 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_sample(d1, d2);
  endtask

  // drop valid and wait until every reading is back
  task automatic drain();
    if (in_live) in_tvalid <= 1'b0;
    in_live = 1'b0;
    while (sb.due_readings.size() != 0) @(posedge clk);
  endtask

  task automatic write_coef(input int idx, input logic [COEF_W-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 5'(idx * 4);
    cfg_pwdata  <= {16'($urandom), val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_coef(idx, val);
  endtask

  task automatic load_coefs(input coef_t c);
    drain();
    write_coef(REG_C1, c.c1);
    write_coef(REG_C2, c.c2);
    write_coef(REG_C3, c.c3);
    write_coef(REG_C4, c.c4);
    write_coef(REG_C5, c.c5);
    write_coef(REG_C6, c.c6);
    // unused addresses: the writes must leave the coefficients alone
    write_coef(SPARE_IDX, 16'($urandom));
    write_coef(SPARE_IDX + 1, 16'($urandom));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic run_random(input int count);
    logic [RAW_W-1:0] d1, d2;
    longint near;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) drain();
      // mostly fresh samples; now and then repeat the last one
      if (i == 0 || $urandom_range(0, 9) != 0) begin
        if ($urandom_range(0, 15) == 0) d1 = $urandom_range(0, 1) ? RAW_MAX : '0;
        else d1 = RAW_W'($urandom);
        if ($urandom_range(0, 9) < 4) begin
          // land around the reference temperature to hit both branches often
          near = longint'(sb.coefs.c5) * 256 + longint'($urandom_range(0, 4194304)) - 2097152;
          if (near < 0) near = 0;
          else if (near > longint'(RAW_MAX)) near = longint'(RAW_MAX);
          d2 = near[RAW_W-1:0];
        end else begin
          d2 = RAW_W'($urandom);
        end
      end
      send_pair(d1, d2);
    end
  endtask

  initial begin
    longint ref_t, cold_dt;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // coefficients still at reset
    send_pair('0, '0);
    send_pair(RAW_MAX, RAW_MAX);
    send_pair(RAW_MAX, '0);
    send_pair('0, RAW_MAX);
    send_pair(24'd12345, 24'd6543210);

    load_coefs(TYPICAL_CAL);
    ref_t   = longint'(TYPICAL_CAL.c5) * 256;
    cold_dt = (longint'(3500) <<< 23) / longint'(TYPICAL_CAL.c6);
    send_pair(24'd8077636, 24'd8569150);
    send_pair(24'd8077636, 24'd8569150);
    // exactly at 20.00 C, just below, and both sides of -15.00 C
    send_pair(24'($urandom), 24'(ref_t));
    send_pair(24'($urandom), 24'(ref_t - 1));
    send_pair(24'($urandom), 24'(ref_t - cold_dt));
    send_pair(24'($urandom), 24'(ref_t - cold_dt - 1));
    send_pair(RAW_MAX, '0);
    send_pair('0, RAW_MAX);
    send_pair(RAW_MAX, RAW_MAX);
    rx_hold_req <= 1'b1;
    run_random(200);

    load_coefs('1);
    send_pair('0, '0);
    send_pair(RAW_MAX, RAW_MAX);
    send_pair(RAW_MAX, '0);
    send_pair('0, RAW_MAX);
    run_random(80);

    load_coefs('0);
    run_random(40);

    repeat (4) begin
      load_coefs(coef_t'({$urandom, $urandom, $urandom}));
      run_random(95);
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.due_readings.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
